// ----- rtl/core/mcas_pkg.sv -----
// Package with the constants, types and command/status structs of the channel silencer.
`timescale 1ns / 1ps
`default_nettype none

package mcas_pkg;

   // Number of tracked MIDI ports and channels per port.
   localparam int PORTS        = 4;
   localparam int CHANNELS     = 16;
   localparam int MAP_BITS     = PORTS * CHANNELS;
   localparam int MAP_IDX_BITS = $clog2(MAP_BITS);

   typedef logic [MAP_IDX_BITS-1:0] map_idx_type;
   typedef logic [MAP_BITS-1:0]     map_type;

   // Input operation codes.
   localparam logic OP_EVENT  = 1'b0;
   localparam logic OP_MARKER = 1'b1;

   // MIDI status and controller constants.
   localparam logic [7:0] ST_VOICE_MIN     = 8'h80;
   localparam logic [7:0] ST_SYSTEM_MIN    = 8'hF0;
   localparam logic [3:0] KIND_NOTE_ON     = 4'h9;
   localparam logic [3:0] KIND_CONTROL     = 4'hB;
   localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_event;   // an event transfer completes on the input
      logic accept_marker;  // a discontinuity marker transfer completes
      logic scan_step;      // move the scan index down by one
      logic scan_emit;      // load an all-sound-off for the scanned pair
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;      // output register can take a result this cycle
      logic map_empty;      // no pair is active
      logic scan_hit;       // pair under the scan index is active
      logic scan_last;      // no pair other than the one under the scan index is active
   } sts_type;

endpackage

`default_nettype wire

// ----- rtl/core/mcas_ctrl.sv -----
// Controller state machine: input handshake and the all-sound-off scan sequence.
`timescale 1ns / 1ps
`default_nettype none

module mcas_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_operation,
   input  wire mcas_pkg::sts_type sts,
   output mcas_pkg::cmd_type     cmd
);
   import mcas_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   logic state_ff;
   logic state_in;
   logic accept;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      accept    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = sts.slot_free;
            accept    = req_valid && sts.slot_free;
            if (accept) begin
               if (req_operation == OP_MARKER) begin
                  cmd.accept_marker = 1'b1;
                  if (!sts.map_empty) begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  cmd.accept_event = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            // Inactive pairs are skipped at once; an active one waits for the output slot.
            cmd.scan_emit = sts.scan_hit && sts.slot_free;
            cmd.scan_step = !sts.scan_hit || sts.slot_free;
            if (cmd.scan_emit && sts.scan_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // The input is held off for the whole scan.
   a_no_accept_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> !req_ready)
      else $error("input accepted during scan");

   // A marker that finds active pairs always starts a scan.
   a_marker_starts_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_marker && !sts.map_empty |=> state_ff == ST_SCAN)
      else $error("marker with active pairs did not start a scan");

   // The scan ends exactly on its last emitted result.
   a_scan_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && cmd.scan_emit && sts.scan_last |=> state_ff == ST_IDLE)
      else $error("scan did not end after its last result");

endmodule

`default_nettype wire

// ----- rtl/core/mcas_datapath.sv -----
// Datapath: generation and active-pair registers, scan index and output register.
`timescale 1ns / 1ps
`default_nettype none

module mcas_datapath (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mcas_pkg::cmd_type cmd,
   output mcas_pkg::sts_type      sts,
   input  wire logic [7:0]        req_status_byte,
   input  wire logic [7:0]        req_data_first,
   input  wire logic [7:0]        req_data_second,
   input  wire logic [7:0]        req_port_number,
   input  wire logic              req_transport_bound,
   input  wire logic [31:0]       req_generation,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_status,
   output logic [7:0]             rsp_out_data_first,
   output logic [7:0]             rsp_out_data_second,
   output logic [7:0]             rsp_out_port,
   output logic [31:0]            rsp_out_generation,
   output logic                   rsp_out_internal,
   output logic                   rsp_out_last
);
   import mcas_pkg::*;

   logic [31:0] gen_ff, gen_in;
   map_type     map_ff, map_in;
   map_idx_type scan_idx_ff, scan_idx_in;

   logic        valid_ff, valid_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  data1_ff, data1_in;
   logic [7:0]  data2_ff, data2_in;
   logic [7:0]  port_ff, port_in;
   logic [31:0] ogen_ff, ogen_in;
   logic        internal_ff, internal_in;
   logic        last_ff, last_in;

   logic        stale;
   logic        tracked;
   logic [11:0] pair_wide;
   map_idx_type pair_idx;
   map_type     scan_bit;
   logic        load;

   assign stale     = req_transport_bound && (req_generation < gen_ff);
   assign tracked   = req_transport_bound && (req_status_byte >= ST_VOICE_MIN)
                      && (req_status_byte < ST_SYSTEM_MIN)
                      && (req_port_number < 8'(PORTS));
   assign pair_wide = {req_port_number, req_status_byte[3:0]};
   assign pair_idx  = pair_wide[MAP_IDX_BITS-1:0];
   assign scan_bit  = map_type'(1) << scan_idx_ff;

   assign sts.slot_free = !valid_ff || rsp_ready;
   assign sts.map_empty = (map_ff == '0);
   assign sts.scan_hit  = map_ff[scan_idx_ff];
   assign sts.scan_last = ((map_ff & ~scan_bit) == '0);

   assign load = (cmd.accept_event && !stale) || cmd.scan_emit;

   always_comb begin
      gen_in      = gen_ff;
      map_in      = map_ff;
      scan_idx_in = scan_idx_ff;
      valid_in    = valid_ff && !rsp_ready;
      status_in   = status_ff;
      data1_in    = data1_ff;
      data2_in    = data2_ff;
      port_in     = port_ff;
      ogen_in     = ogen_ff;
      internal_in = internal_ff;
      last_in     = last_ff;

      if (cmd.accept_event && !stale) begin
         valid_in    = 1'b1;
         status_in   = req_status_byte;
         data1_in    = req_data_first;
         data2_in    = req_data_second;
         port_in     = req_port_number;
         ogen_in     = req_generation;
         internal_in = 1'b0;
         last_in     = 1'b1;
         if (tracked) begin
            if (req_status_byte[7:4] == KIND_NOTE_ON && req_data_second != 8'd0) begin
               map_in[pair_idx] = 1'b1;
            end else if (req_status_byte[7:4] == KIND_CONTROL
                         && req_data_first == CC_ALL_SOUND_OFF) begin
               map_in[pair_idx] = 1'b0;
            end
         end
      end

      if (cmd.accept_marker) begin
         if (req_generation > gen_ff) begin
            gen_in = req_generation;
         end
         scan_idx_in = map_idx_type'(MAP_BITS - 1);
      end

      if (cmd.scan_emit) begin
         valid_in    = 1'b1;
         status_in   = {KIND_CONTROL, scan_idx_ff[3:0]};
         data1_in    = CC_ALL_SOUND_OFF;
         data2_in    = 8'd0;
         port_in     = 8'(scan_idx_ff >> 4);
         ogen_in     = gen_ff;
         internal_in = 1'b1;
         last_in     = sts.scan_last;
         map_in      = map_ff & ~scan_bit;
      end

      if (cmd.scan_step) begin
         scan_idx_in = scan_idx_ff - map_idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         map_ff      <= '0;
         scan_idx_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         gen_ff      <= gen_in;
         map_ff      <= map_in;
         scan_idx_ff <= scan_idx_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      data1_ff    <= data1_in;
      data2_ff    <= data2_in;
      port_ff     <= port_in;
      ogen_ff     <= ogen_in;
      internal_ff <= internal_in;
      last_ff     <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_status      = status_ff;
   assign rsp_out_data_first  = data1_ff;
   assign rsp_out_data_second = data2_ff;
   assign rsp_out_port        = port_ff;
   assign rsp_out_generation  = ogen_ff;
   assign rsp_out_internal    = internal_ff;
   assign rsp_out_last        = last_ff;

   // A new result is only loaded when the output register is empty or the pending one leaves in the same cycle.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> sts.slot_free)
      else $error("output register overwritten");

   // A stale event leaves no result behind.
   a_stale_dropped: assert property (@(posedge clock) disable iff (reset)
      cmd.accept_event && stale && sts.slot_free |=> !valid_ff)
      else $error("stale event produced a result");

   // The map is clear once the last all-sound-off has been loaded.
   a_map_cleared: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_emit && sts.scan_last |=> map_ff == '0)
      else $error("map not clear after scan");

   // The transport generation never moves backward.
   a_gen_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> gen_ff >= $past(gen_ff))
      else $error("generation decreased");

endmodule

`default_nettype wire

// ----- rtl/core/midi_channel_activity_silencer_unit.sv -----
// Top level of the MIDI channel activity silencer: controller plus datapath.
//
// Input channel (req_*): one transfer carries a MIDI event or a transport
// discontinuity marker. Result channel (rsp_*): forwarded events and generated
// all-sound-off messages, with rsp_out_last marking the last result of an input.
// Both channels use valid/ready; a transfer completes when both are high.
// An event is taken and its result appears in the output register on the next
// cycle; events pass at one per cycle while the receiver keeps up.
// A stale transport-bound event is dropped and gives no result.
// A marker starts no scan when no pair is active. Otherwise the scan walks the
// 64 (port, channel) pairs from port 3 channel 15 down, one pair per cycle while
// no active pair waits on a receiver stall, and ends on the last active pair;
// the input is not ready during the scan.
// When the receiver stalls, the output register holds its result and the input
// is ready only in a cycle in which that register empties or is empty.
// Synchronous active-high reset clears the generation to zero, clears all
// active pairs and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module midi_channel_activity_silencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_status_byte,
   input  wire logic [7:0]  req_data_first,
   input  wire logic [7:0]  req_data_second,
   input  wire logic [7:0]  req_port_number,
   input  wire logic        req_transport_bound,
   input  wire logic [31:0] req_generation,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_status,
   output logic [7:0]       rsp_out_data_first,
   output logic [7:0]       rsp_out_data_second,
   output logic [7:0]       rsp_out_port,
   output logic [31:0]      rsp_out_generation,
   output logic             rsp_out_internal,
   output logic             rsp_out_last
);
   import mcas_pkg::*;

   cmd_type cmd;
   sts_type sts;

   mcas_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   mcas_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_status_byte     (req_status_byte),
      .req_data_first      (req_data_first),
      .req_data_second     (req_data_second),
      .req_port_number     (req_port_number),
      .req_transport_bound (req_transport_bound),
      .req_generation      (req_generation),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_status      (rsp_out_status),
      .rsp_out_data_first  (rsp_out_data_first),
      .rsp_out_data_second (rsp_out_data_second),
      .rsp_out_port        (rsp_out_port),
      .rsp_out_generation  (rsp_out_generation),
      .rsp_out_internal    (rsp_out_internal),
      .rsp_out_last        (rsp_out_last)
   );

endmodule

`default_nettype wire
